@@ rtl/qora_pkg.sv @@
// Shared types and codes for the quaternion offset rotate/add block.
// No dependencies; qora_rot_mat, qora_dot_mac and the top level import this package.
package qora_pkg;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAT,
		ST_DOT,
		ST_DONE
	} state_t;

	// Input word command codes
	localparam logic CMD_ORIENT   = 1'b0;
	localparam logic CMD_POSITION = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVER_Z = 2'd2;

	// Control from the sequencer to the serial matrix builder
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} mat_ctrl_t;

	// Control from the sequencer to the per-axis serial MACs
	typedef struct packed {
		logic load;
		logic step;
		logic off_msb;
		logic rel_en;
		logic rel_msb;
	} mac_ctrl_t;

endpackage

@@ rtl/qora_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing; used by the top level and its environment.
interface qora_item_if #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) ();
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic signed [POS_WIDTH-1:0]  rel_x;
	logic signed [POS_WIDTH-1:0]  rel_y;
	logic signed [POS_WIDTH-1:0]  rel_z;
	logic signed [QUAT_WIDTH-1:0] new_qw;
	logic signed [QUAT_WIDTH-1:0] new_qx;
	logic signed [QUAT_WIDTH-1:0] new_qy;
	logic signed [QUAT_WIDTH-1:0] new_qz;

	modport source (
		output valid, cmd, rel_x, rel_y, rel_z, new_qw, new_qx, new_qy, new_qz,
		input  ready
	);
	modport sink (
		input  valid, cmd, rel_x, rel_y, rel_z, new_qw, new_qx, new_qy, new_qz,
		output ready
	);
endinterface

interface qora_result_if #(
	parameter int POS_WIDTH = 32
) ();
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] adj_x;
	logic signed [POS_WIDTH-1:0] adj_y;
	logic signed [POS_WIDTH-1:0] adj_z;

	modport source (
		output valid, adj_x, adj_y, adj_z,
		input  ready
	);
	modport sink (
		input  valid, adj_x, adj_y, adj_z,
		output ready
	);
endinterface

@@ rtl/qora_rot_mat.sv @@
// Serial-parallel builder and store of the rounded 3x3 rotation matrix.
// Depends on qora_pkg. One quaternion bit of each part is consumed per step.
module qora_rot_mat #(
	parameter int QUAT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qora_pkg::mat_ctrl_t               ctrl,
	input  logic signed [QUAT_WIDTH-1:0]      q_w,
	input  logic signed [QUAT_WIDTH-1:0]      q_x,
	input  logic signed [QUAT_WIDTH-1:0]      q_y,
	input  logic signed [QUAT_WIDTH-1:0]      q_z,
	output logic [8:0][QUAT_WIDTH+3:0]        elem
);
	import qora_pkg::*;

	localparam int FRAC   = QUAT_WIDTH - 2;
	localparam int E_W    = QUAT_WIDTH + 4;
	localparam int EACC_W = QUAT_WIDTH + 4;
	// rounding bias at weight one, and the 1.0 of the diagonal at the sign step
	localparam logic signed [EACC_W-1:0] BIAS      = EACC_W'(2 ** (FRAC - 1));
	localparam logic signed [EACC_W-1:0] DIAG_ADD  = EACC_W'(2 ** (QUAT_WIDTH - 3));
	localparam logic signed [EACC_W-1:0] IDENT_ACC = EACC_W'(2 ** (QUAT_WIDTH - 4));

	logic signed [QUAT_WIDTH-1:0] par_w_q, par_x_q, par_y_q, par_z_q;
	logic        [QUAT_WIDTH-1:0] sh_w_q, sh_x_q, sh_y_q, sh_z_q;
	logic signed [EACC_W-1:0]     acc_q [9];
	logic        [1:0]            low_q [9];
	logic signed [EACC_W-1:0]     sum   [9];
	logic signed [EACC_W-1:0]     diag;
	logic                         wb, xb, yb, zb;

	// one partial product: doubled operand, negated on the sign bit step
	function automatic logic signed [EACC_W-1:0] tm(
		input logic                         b,
		input logic                         neg,
		input logic signed [QUAT_WIDTH-1:0] v
	);
		logic signed [EACC_W-1:0] d;
		d = EACC_W'(v) <<< 1;
		return b ? (neg ? -d : d) : '0;
	endfunction

	// operand latch and bit shifters
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			par_w_q <= q_w;
			par_x_q <= q_x;
			par_y_q <= q_y;
			par_z_q <= q_z;
			sh_w_q  <= q_w;
			sh_x_q  <= q_x;
			sh_y_q  <= q_y;
			sh_z_q  <= q_z;
		end else if (ctrl.step) begin
			sh_w_q <= sh_w_q >> 1;
			sh_x_q <= sh_x_q >> 1;
			sh_y_q <= sh_y_q >> 1;
			sh_z_q <= sh_z_q >> 1;
		end
	end

	assign wb = sh_w_q[0];
	assign xb = sh_x_q[0];
	assign yb = sh_y_q[0];
	assign zb = sh_z_q[0];

	// element accumulate terms for this step
	always_comb begin
		diag   = ctrl.last ? DIAG_ADD : '0;
		sum[0] = acc_q[0] - tm(yb, ctrl.last, par_y_q) - tm(zb, ctrl.last, par_z_q) + diag;
		sum[1] = acc_q[1] + tm(xb, ctrl.last, par_y_q) - tm(wb, ctrl.last, par_z_q);
		sum[2] = acc_q[2] + tm(xb, ctrl.last, par_z_q) + tm(wb, ctrl.last, par_y_q);
		sum[3] = acc_q[3] + tm(xb, ctrl.last, par_y_q) + tm(wb, ctrl.last, par_z_q);
		sum[4] = acc_q[4] - tm(xb, ctrl.last, par_x_q) - tm(zb, ctrl.last, par_z_q) + diag;
		sum[5] = acc_q[5] + tm(yb, ctrl.last, par_z_q) - tm(wb, ctrl.last, par_x_q);
		sum[6] = acc_q[6] + tm(xb, ctrl.last, par_z_q) - tm(wb, ctrl.last, par_y_q);
		sum[7] = acc_q[7] + tm(yb, ctrl.last, par_z_q) + tm(wb, ctrl.last, par_x_q);
		sum[8] = acc_q[8] - tm(xb, ctrl.last, par_x_q) - tm(yb, ctrl.last, par_y_q) + diag;
	end

	// accumulators double as the matrix store; reset gives identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				acc_q[i] <= (i % 4 == 0) ? IDENT_ACC : '0;
				low_q[i] <= '0;
			end
		end else if (ctrl.load) begin
			for (int i = 0; i < 9; i++) begin
				acc_q[i] <= BIAS;
				low_q[i] <= '0;
			end
		end else if (ctrl.step) begin
			for (int i = 0; i < 9; i++) begin
				acc_q[i] <= sum[i] >>> 1;
				low_q[i] <= {sum[i][0], low_q[i][1]};
			end
		end
	end

	// rounded element: high accumulator bits over the two kept low bits
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			elem[i] = {acc_q[i][E_W-3:0], low_q[i]};
		end
	end

endmodule

@@ rtl/qora_dot_mac.sv @@
// Serial multiply-accumulate for one output axis: row of the matrix times
// the offset, plus the relative position, rounded and saturated. Uses qora_pkg.
module qora_dot_mac #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) (
	input  logic                        clk,
	input  qora_pkg::mac_ctrl_t         ctrl,
	input  logic [2:0][QUAT_WIDTH+3:0]  elem,
	input  logic [2:0]                  off_bit,
	input  logic signed [POS_WIDTH-1:0] rel,
	output logic signed [POS_WIDTH-1:0] adj
);
	import qora_pkg::*;

	localparam int FRAC  = QUAT_WIDTH - 2;
	localparam int ACC_W = QUAT_WIDTH + 7;
	localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'(2 ** (FRAC - 1));
	localparam logic signed [ACC_W-1:0] ONE   = ACC_W'(1);
	localparam logic [POS_WIDTH-1:0]    POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic [POS_WIDTH-1:0]    POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

	logic signed [ACC_W-1:0]   acc_q;
	logic        [POS_WIDTH-1:0] low_q;
	logic        [POS_WIDTH-1:0] rel_sh_q;
	logic signed [ACC_W-1:0]   sum;
	logic                      fits;

	// add the selected row elements and the current position bit
	always_comb begin
		sum = acc_q;
		for (int j = 0; j < 3; j++) begin
			if (off_bit[j]) begin
				sum = ctrl.off_msb ? sum - ACC_W'(signed'(elem[j]))
				                   : sum + ACC_W'(signed'(elem[j]));
			end
		end
		if (ctrl.rel_en && rel_sh_q[0]) begin
			sum = ctrl.rel_msb ? sum - ONE : sum + ONE;
		end
	end

	// low product bits shift out into low_q; only the top word is kept
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q    <= BIAS;
			low_q    <= '0;
			rel_sh_q <= rel;
		end else if (ctrl.step) begin
			acc_q <= sum >>> 1;
			low_q <= {sum[0], low_q[POS_WIDTH-1:1]};
			if (ctrl.rel_en) begin
				rel_sh_q <= rel_sh_q >> 1;
			end
		end
	end

	// saturate: the high bits must all match the result sign
	assign fits = (acc_q == '0 && !low_q[POS_WIDTH-1]) ||
	              ((&acc_q) && low_q[POS_WIDTH-1]);
	assign adj  = fits ? low_q : (acc_q[ACC_W-1] ? POS_MIN : POS_MAX);

endmodule

@@ rtl/quaternion_offset_rotate_add_unit.sv @@
// Quaternion offset rotate/add unit: rotates a body-frame offset by the
// stored attitude and adds it to a relative position, with saturation.
// Depends on qora_pkg, qora_if, qora_rot_mat and qora_dot_mac.
//
// Usage:
//  - item channel (valid/ready): cmd 0 carries a Q1.14 quaternion that
//    replaces the stored attitude and yields no result; cmd 1 carries a
//    Q16.16 relative position and yields one result word.
//  - result channel (valid/ready): adj_x/y/z, saturated Q16.16.
//  - cfg port: cfg_we, cfg_index, cfg_data write the lever arm x/y/z
//    (index 0..2); other indexes are ignored. Write only while no word is
//    in flight.
// Timing: a quaternion word runs QUAT_WIDTH steps after acceptance, one
// quaternion bit per cycle through the matrix builder. A position word runs
// POS_WIDTH + QUAT_WIDTH - 2 serial MAC steps and then loads the output register once it is free.
// The input is taken only when the sequencer is idle. A finished result
// sits in the output register; the next word is accepted meanwhile, and a
// following result waits in its MACs until the register frees up.
// Reset sets the attitude to identity, offsets to zero, output empty.
module quaternion_offset_rotate_add_unit #(
	parameter int POS_WIDTH  = 32,
	parameter int QUAT_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	qora_item_if.sink                        item,
	qora_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [qora_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [POS_WIDTH-1:0]             cfg_data
);
	import qora_pkg::*;

	localparam int FRAC  = QUAT_WIDTH - 2;
	localparam int NBITS = POS_WIDTH + FRAC;
	localparam int CNT_W = $clog2(NBITS);
	localparam int E_W   = QUAT_WIDTH + 4;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [POS_WIDTH-1:0]   off_x_q, off_y_q, off_z_q;
	logic [POS_WIDTH-1:0]   osh_x_q, osh_y_q, osh_z_q;
	logic                   res_valid_q;
	logic [POS_WIDTH-1:0]   adj_x_q, adj_y_q, adj_z_q;

	logic                   item_ready;
	logic                   item_acc;
	logic                   cnt_last_mat;
	logic                   cnt_last_dot;
	logic                   out_free;
	logic                   out_load;
	mat_ctrl_t              mat_ctrl;
	mac_ctrl_t              mac_ctrl;
	logic [8:0][E_W-1:0]    mat;
	logic [2:0]             off_bit;
	logic signed [POS_WIDTH-1:0] adj_x, adj_y, adj_z;

	assign item_acc     = item.valid && item_ready;
	assign cnt_last_mat = (cnt_q == CNT_W'(QUAT_WIDTH - 1));
	assign cnt_last_dot = (cnt_q == CNT_W'(NBITS - 1));
	assign out_free     = !res_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					state_d = (item.cmd == CMD_ORIENT) ? ST_MAT : ST_DOT;
				end
			end
			ST_MAT: begin
				if (cnt_last_mat) state_d = ST_IDLE;
			end
			ST_DOT: begin
				if (cnt_last_dot) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready       = (state_q == ST_IDLE);
		mat_ctrl.load    = item_acc && (item.cmd == CMD_ORIENT);
		mat_ctrl.step    = (state_q == ST_MAT);
		mat_ctrl.last    = (state_q == ST_MAT) && cnt_last_mat;
		mac_ctrl.load    = item_acc && (item.cmd == CMD_POSITION);
		mac_ctrl.step    = (state_q == ST_DOT);
		mac_ctrl.off_msb = (cnt_q == CNT_W'(POS_WIDTH - 1));
		mac_ctrl.rel_en  = (cnt_q >= CNT_W'(FRAC));
		mac_ctrl.rel_msb = cnt_last_dot;
		out_load         = (state_q == ST_DONE) && out_free;
	end

	assign item.ready = item_ready;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (item_acc) begin
				cnt_q <= '0;
			end else if (mat_ctrl.step || mac_ctrl.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVER_X: off_x_q <= cfg_data;
				REG_LEVER_Y: off_y_q <= cfg_data;
				REG_LEVER_Z: off_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// offset bit shifters shared by all three axes; zeros fill from the top
	always_ff @(posedge clk) begin
		if (mac_ctrl.load) begin
			osh_x_q <= off_x_q;
			osh_y_q <= off_y_q;
			osh_z_q <= off_z_q;
		end else if (mac_ctrl.step) begin
			osh_x_q <= osh_x_q >> 1;
			osh_y_q <= osh_y_q >> 1;
			osh_z_q <= osh_z_q >> 1;
		end
	end

	assign off_bit = {osh_z_q[0], osh_y_q[0], osh_x_q[0]};

	qora_rot_mat #(
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mat_ctrl),
		.q_w    (item.new_qw),
		.q_x    (item.new_qx),
		.q_y    (item.new_qy),
		.q_z    (item.new_qz),
		.elem   (mat)
	);

	qora_dot_mac #(
		.POS_WIDTH  (POS_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_mac_x (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.elem    ({mat[2], mat[1], mat[0]}),
		.off_bit (off_bit),
		.rel     (item.rel_x),
		.adj     (adj_x)
	);

	qora_dot_mac #(
		.POS_WIDTH  (POS_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_mac_y (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.elem    ({mat[5], mat[4], mat[3]}),
		.off_bit (off_bit),
		.rel     (item.rel_y),
		.adj     (adj_y)
	);

	qora_dot_mac #(
		.POS_WIDTH  (POS_WIDTH),
		.QUAT_WIDTH (QUAT_WIDTH)
	) u_mac_z (
		.clk     (clk),
		.ctrl    (mac_ctrl),
		.elem    ({mat[8], mat[7], mat[6]}),
		.off_bit (off_bit),
		.rel     (item.rel_z),
		.adj     (adj_z)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			adj_x_q <= adj_x;
			adj_y_q <= adj_y;
			adj_z_q <= adj_z;
		end
	end

	assign result.valid = res_valid_q;
	assign result.adj_x = adj_x_q;
	assign result.adj_y = adj_y_q;
	assign result.adj_z = adj_z_q;

	// matrix build never runs past the quaternion width
	a_mat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAT) |-> (cnt_q < CNT_W'(QUAT_WIDTH)))
		else $error("matrix step counter overran");

	// last MAC step hands over to the output stage
	a_dot_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOT && cnt_last_dot) |=> (state_q == ST_DONE))
		else $error("MAC pass did not finish into DONE");

	// a new result only appears after a finished position word
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside DONE");

	// an attitude word starts a matrix build and nothing else
	a_orient: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.cmd == CMD_ORIENT) |=> (state_q == ST_MAT && cnt_q == '0))
		else $error("attitude word did not start matrix build");

endmodule
